// ===== sv/laser_spot_window_tracker_defines.svh =====
// Assertion macros shared by the laser spot window tracker RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef LASER_SPOT_WINDOW_TRACKER_DEFINES_SVH
`define LASER_SPOT_WINDOW_TRACKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LSWT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lswt: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LSWT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lswt: next-cycle check failed");

`endif

// ===== sv/lswt_pkg.sv =====
// Shared constants, types and helpers of the laser spot window tracker.
// No dependencies; imported by every module of the block.
package lswt_pkg;

    localparam int FRAME_SIDE = 128;
    localparam int COORD_W    = $clog2(FRAME_SIDE);
    localparam int HALF_W     = 7;
    localparam int SPAN_W     = ((COORD_W > HALF_W) ? COORD_W : HALF_W) + 1;
    localparam int CHAN_W     = 8;
    localparam int WGT_W      = 8;
    localparam int PROD_W     = CHAN_W + WGT_W;
    localparam int SCORE_W    = 18;
    localparam int CMP_W      = 21;
    localparam int OUT_XY_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = COORD_W'(FRAME_SIDE - 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_WEIGHT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WEIGHT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW       = 2'd3;

    localparam logic [WGT_W-1:0]  RST_HUE_WEIGHT        = 8'd2;
    localparam logic [WGT_W-1:0]  RST_SATURATION_WEIGHT = 8'd2;
    localparam logic [WGT_W-1:0]  RST_VALUE_WEIGHT      = 8'd1;
    localparam logic [HALF_W-1:0] RST_HALF_WINDOW       = 7'd21;

    typedef struct packed {
        logic [WGT_W-1:0] hue_w;
        logic [WGT_W-1:0] sat_w;
        logic [WGT_W-1:0] val_w;
    } t_weights;

    // Pixel as held in the input register
    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bri;
        logic              last;
        t_coord            x;
        t_coord            y;
    } t_pix;

    typedef struct packed {
        logic [PROD_W-1:0] prod_h;
        logic [PROD_W-1:0] prod_s;
        logic [PROD_W-1:0] prod_v;
        logic              last;
        t_coord            x;
        t_coord            y;
    } t_prod;

    // Scored pixel; score10 and score9 carry the threshold test 10*w > 9*p
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [CMP_W-1:0]   score10;
        logic [CMP_W-1:0]   score9;
        logic               last;
        t_coord             x;
        t_coord             y;
    } t_scored;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic [SCORE_W-1:0] score;
        logic [CMP_W-1:0]   score10;
        logic [CMP_W-1:0]   score9;
    } t_best;

    function automatic logic [OUT_XY_W-1:0] to_out_xy(input t_coord c);
        logic [SPAN_W-1:0] wide;
        wide = SPAN_W'(c);
        return wide[OUT_XY_W-1:0];
    endfunction

endpackage

// ===== sv/laser_spot_window_tracker.sv =====
// Top level of the laser spot window tracker: config registers, raster
// counters, input register and the score and tracker stages.
// Depends on lswt_pkg, lswt_score and lswt_tracker.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------------------
//  cfg      | in        | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//  pixel    | in        | i_in_valid / o_in_ready     | i_hue, i_saturation, i_brightness,
//           |           |                             | i_frame_end
//  result   | out       | o_out_valid / i_out_ready   | o_spot_x, o_spot_y, o_spot_score,
//           |           |                             | o_from_window
//
// One pixel transfer per cycle while the pipeline is not stalled; a pixel passes
// the input register, product register and sum register before the tracker stage.
// Reset (synchronous, active low) restores the register defaults, clears the
// raster counters, previous spot and running bests, and empties the pipeline.
// The whole pipeline stalls only when a frame-end pixel reaches the tracker
// while the previous result is still waiting in the output register.
module laser_spot_window_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lswt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lswt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lswt_pkg::CHAN_W-1:0]     i_hue,
    input  logic [lswt_pkg::CHAN_W-1:0]     i_saturation,
    input  logic [lswt_pkg::CHAN_W-1:0]     i_brightness,
    input  logic                            i_frame_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lswt_pkg::OUT_XY_W-1:0]   o_spot_x,
    output logic [lswt_pkg::OUT_XY_W-1:0]   o_spot_y,
    output logic [lswt_pkg::SCORE_W-1:0]    o_spot_score,
    output logic                            o_from_window
);
    import lswt_pkg::*;

    logic [WGT_W-1:0]  r_hue_weight;
    logic [WGT_W-1:0]  r_sat_weight;
    logic [WGT_W-1:0]  r_val_weight;
    logic [HALF_W-1:0] r_half_window;
    t_coord            r_col;
    t_coord            r_row;
    logic              r_a_valid;
    t_pix              r_a;
    t_pix              n_a;
    t_weights          w_weights;
    logic              w_hold;
    logic              w_adv;
    logic              w_accept;
    logic              w_c_valid;
    t_scored           w_c;

    // Configuration registers: the user must write them only while the pipeline is empty; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_weight  <= RST_HUE_WEIGHT;
            r_sat_weight  <= RST_SATURATION_WEIGHT;
            r_val_weight  <= RST_VALUE_WEIGHT;
            r_half_window <= RST_HALF_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HUE_WEIGHT:        r_hue_weight  <= i_cfg_data[WGT_W-1:0];
                CFG_SATURATION_WEIGHT: r_sat_weight  <= i_cfg_data[WGT_W-1:0];
                CFG_VALUE_WEIGHT:      r_val_weight  <= i_cfg_data[WGT_W-1:0];
                CFG_HALF_WINDOW:       r_half_window <= i_cfg_data[HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_weights = '{hue_w: r_hue_weight, sat_w: r_sat_weight, val_w: r_val_weight};

    // Every stage advances together; the tracker raises hold on a result collision
    assign w_adv      = !w_hold;
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    // Raster position: stamp each pixel at transfer, wrap at the frame side,
    // return to the origin after the frame-end pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (i_frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_col == COORD_MAX) begin
                r_col <= '0;
                r_row <= (r_row == COORD_MAX) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_comb begin
        n_a.hue  = i_hue;
        n_a.sat  = i_saturation;
        n_a.bri  = i_brightness;
        n_a.last = i_frame_end;
        n_a.x    = r_col;
        n_a.y    = r_row;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a <= n_a;
        end
    end

    lswt_score u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (r_a_valid),
        .i_pix     (r_a),
        .i_weights (w_weights),
        .o_valid   (w_c_valid),
        .o_scored  (w_c)
    );

    lswt_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_c_valid),
        .i_scored      (w_c),
        .i_half_window (r_half_window),
        .o_hold        (w_hold),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_spot_x      (o_spot_x),
        .o_spot_y      (o_spot_y),
        .o_spot_score  (o_spot_score),
        .o_from_window (o_from_window)
    );

endmodule

// ===== sv/lswt_score.sv =====
// Score pipeline: weight products, then weighted sum and its x10 / x9 forms.
// Depends on lswt_pkg.
module lswt_score (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  lswt_pkg::t_pix    i_pix,
    input  lswt_pkg::t_weights i_weights,
    output logic              o_valid,
    output lswt_pkg::t_scored o_scored
);
    import lswt_pkg::*;

    logic               r_b_valid;
    logic               r_c_valid;
    t_prod              r_b;
    t_prod              n_b;
    t_scored            r_c;
    t_scored            n_c;
    logic [SCORE_W-1:0] w_sum;

    always_comb begin
        n_b.prod_h = PROD_W'(i_weights.hue_w) * PROD_W'(i_pix.hue);
        n_b.prod_s = PROD_W'(i_weights.sat_w) * PROD_W'(i_pix.sat);
        n_b.prod_v = PROD_W'(i_weights.val_w) * PROD_W'(i_pix.bri);
        n_b.last   = i_pix.last;
        n_b.x      = i_pix.x;
        n_b.y      = i_pix.y;
    end

    assign w_sum = SCORE_W'(r_b.prod_h) + SCORE_W'(r_b.prod_s) + SCORE_W'(r_b.prod_v);

    always_comb begin
        n_c.score   = w_sum;
        n_c.score10 = (CMP_W'(w_sum) << 3) + (CMP_W'(w_sum) << 1);
        n_c.score9  = (CMP_W'(w_sum) << 3) + CMP_W'(w_sum);
        n_c.last    = r_b.last;
        n_c.x       = r_b.x;
        n_c.y       = r_b.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    assign o_valid  = r_c_valid;
    assign o_scored = r_c;

endmodule

// ===== sv/lswt_window.sv =====
// Search window test: clamp the window around the previous spot, check a pixel.
// Depends on lswt_pkg.
module lswt_window (
    input  lswt_pkg::t_coord            i_prev_x,
    input  lswt_pkg::t_coord            i_prev_y,
    input  logic [lswt_pkg::HALF_W-1:0] i_half_window,
    input  lswt_pkg::t_coord            i_x,
    input  lswt_pkg::t_coord            i_y,
    output logic                        o_in_window
);
    import lswt_pkg::*;

    logic [SPAN_W-1:0] w_half;
    logic [SPAN_W-1:0] w_side;
    logic [SPAN_W-1:0] w_lx;
    logic [SPAN_W-1:0] w_ly;
    logic [SPAN_W-1:0] w_x;
    logic [SPAN_W-1:0] w_y;

    // Low edge of the window on one axis, kept inside the frame
    function automatic logic [SPAN_W-1:0] win_low(input logic [SPAN_W-1:0] center,
                                                  input logic [SPAN_W-1:0] half,
                                                  input logic [SPAN_W-1:0] side);
        logic [SPAN_W-1:0] top;
        logic [SPAN_W-1:0] low;
        top = SPAN_W'(FRAME_SIDE) - side;
        low = center - half;
        if (side >= SPAN_W'(FRAME_SIDE)) begin
            return '0;
        end else if (center < half) begin
            return '0;
        end else if (low > top) begin
            return top;
        end else begin
            return low;
        end
    endfunction

    assign w_half = SPAN_W'(i_half_window);
    assign w_side = w_half << 1;
    assign w_x    = SPAN_W'(i_x);
    assign w_y    = SPAN_W'(i_y);
    assign w_lx   = win_low(SPAN_W'(i_prev_x), w_half, w_side);
    assign w_ly   = win_low(SPAN_W'(i_prev_y), w_half, w_side);

    assign o_in_window = (w_x >= w_lx) && ((w_x - w_lx) < w_side) &&
                         (w_y >= w_ly) && ((w_y - w_ly) < w_side);

endmodule

// ===== sv/lswt_tracker.sv =====
// Running frame and window bests, end-of-frame choice and the result register.
// Depends on lswt_pkg, lswt_window and the assertion macro header.
`include "laser_spot_window_tracker_defines.svh"

module lswt_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  lswt_pkg::t_scored             i_scored,
    input  logic [lswt_pkg::HALF_W-1:0]   i_half_window,
    output logic                          o_hold,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lswt_pkg::OUT_XY_W-1:0] o_spot_x,
    output logic [lswt_pkg::OUT_XY_W-1:0] o_spot_y,
    output logic [lswt_pkg::SCORE_W-1:0]  o_spot_score,
    output logic                          o_from_window
);
    import lswt_pkg::*;

    t_best              r_fbest;
    t_best              r_wbest;
    t_best              r_prev;
    t_best              n_fbest;
    t_best              n_wbest;
    t_best              n_prev;
    t_best              w_cand;
    logic               r_out_valid;
    t_coord             r_out_x;
    t_coord             r_out_y;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_from_win;
    logic               w_in_window;
    logic               w_commit;
    logic               w_take;

    lswt_window u_window (
        .i_prev_x      (r_prev.x),
        .i_prev_y      (r_prev.y),
        .i_half_window (i_half_window),
        .i_x           (i_scored.x),
        .i_y           (i_scored.y),
        .o_in_window   (w_in_window)
    );

    // Stall only when a frame-end pixel would overwrite an untaken result
    assign o_hold   = i_valid && i_scored.last && r_out_valid && !i_out_ready;
    assign w_commit = i_valid && !o_hold;

    always_comb begin
        w_cand.x       = i_scored.x;
        w_cand.y       = i_scored.y;
        w_cand.score   = i_scored.score;
        w_cand.score10 = i_scored.score10;
        w_cand.score9  = i_scored.score9;
        n_fbest = (i_scored.score > r_fbest.score) ? w_cand : r_fbest;
        n_wbest = (w_in_window && (i_scored.score > r_wbest.score)) ? w_cand : r_wbest;
        // 100*w > 90*p is the same test as 10*w > 9*p
        w_take  = n_wbest.score10 > r_prev.score9;
        n_prev  = w_take ? n_wbest : n_fbest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fbest     <= '0;
            r_wbest     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                if (i_scored.last) begin
                    r_prev  <= n_prev;
                    r_fbest <= '0;
                    r_wbest <= '0;
                end else begin
                    r_fbest <= n_fbest;
                    r_wbest <= n_wbest;
                end
            end
            if (w_commit && i_scored.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && i_scored.last) begin
            r_out_x        <= n_prev.x;
            r_out_y        <= n_prev.y;
            r_out_score    <= n_prev.score;
            r_out_from_win <= w_take;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_spot_x      = to_out_xy(r_out_x);
    assign o_spot_y      = to_out_xy(r_out_y);
    assign o_spot_score  = r_out_score;
    assign o_from_window = r_out_from_win;

    `LSWT_ASSERT_IMP(a_window_not_above_frame, i_clk, i_rst_n, 1'b1, r_wbest.score <= r_fbest.score)
    `LSWT_ASSERT_NXT(a_clear_after_end, i_clk, i_rst_n, w_commit && i_scored.last, r_fbest.score == '0 && r_wbest.score == '0 && r_out_valid)
    `LSWT_ASSERT_IMP(a_prev_is_pending_result, i_clk, i_rst_n, r_out_valid, r_prev.score == r_out_score)
    `LSWT_ASSERT_IMP(a_hold_only_on_end, i_clk, i_rst_n, o_hold, i_valid && i_scored.last && r_out_valid)

endmodule

// ===== tb/sv/lswt_spot_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the laser spot window tracker: tracks the config port and both
// streaming channels, predicts each frame's spot and compares it field by field.
// Depends on lswt_pkg for widths, register indexes and reset values.
module lswt_spot_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lswt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lswt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [lswt_pkg::CHAN_W-1:0]     i_hue,
    input  logic [lswt_pkg::CHAN_W-1:0]     i_saturation,
    input  logic [lswt_pkg::CHAN_W-1:0]     i_brightness,
    input  logic                            i_frame_end,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [lswt_pkg::OUT_XY_W-1:0]   i_spot_x,
    input  logic [lswt_pkg::OUT_XY_W-1:0]   i_spot_y,
    input  logic [lswt_pkg::SCORE_W-1:0]    i_spot_score,
    input  logic                            i_from_window,
    output int                              o_mismatch_count,
    output int                              o_pending
);
    import lswt_pkg::*;

    typedef struct {
        t_coord             x;
        t_coord             y;
        logic [SCORE_W-1:0] score;
    } t_lead;

    typedef struct {
        logic [OUT_XY_W-1:0] x;
        logic [OUT_XY_W-1:0] y;
        logic [SCORE_W-1:0]  score;
        logic                from_window;
    } t_spot_result;

    logic [WGT_W-1:0]  hue_w, sat_w, val_w;
    logic [HALF_W-1:0] half_w;
    t_coord            col, row;
    t_lead             prev_spot, win_lead, frame_lead;
    t_spot_result      spot_q[$];

    // Lower edge of the search window, clamped so the window stays in the frame
    function automatic int unsigned window_origin(input int unsigned center,
                                                  input int unsigned half);
        int unsigned side;
        int unsigned top;
        side = 2 * half;
        if (side >= FRAME_SIDE) begin
            return 0;
        end
        top = FRAME_SIDE - side;
        if (center < half) begin
            return 0;
        end
        if (center - half > top) begin
            return top;
        end
        return center - half;
    endfunction

    task automatic clear_leads();
        win_lead   = '{'0, '0, '0};
        frame_lead = '{'0, '0, '0};
    endtask

    task automatic track_pixel(input logic [CHAN_W-1:0] hue, input logic [CHAN_W-1:0] sat,
                               input logic [CHAN_W-1:0] bri, input logic is_end);
        int unsigned  score, side, lx, ly, x, y;
        logic         in_win, take_win;
        t_spot_result res;
        score = 32'(hue_w) * 32'(hue) + 32'(sat_w) * 32'(sat) + 32'(val_w) * 32'(bri);
        x     = col;
        y     = row;
        side  = 2 * 32'(half_w);
        lx    = window_origin(prev_spot.x, half_w);
        ly    = window_origin(prev_spot.y, half_w);
        in_win = (x >= lx) && (x - lx < side) && (y >= ly) && (y - ly < side);

        // First strictly higher score wins; ties keep the earlier pixel
        if (score > frame_lead.score) begin
            frame_lead = '{t_coord'(x), t_coord'(y), SCORE_W'(score)};
        end
        if (in_win && score > win_lead.score) begin
            win_lead = '{t_coord'(x), t_coord'(y), SCORE_W'(score)};
        end

        if (!is_end) begin
            if (col == COORD_MAX) begin
                col = '0;
                row = (row == COORD_MAX) ? '0 : row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
            return;
        end

        take_win  = (32'(win_lead.score) * 100) > (32'(prev_spot.score) * 90);
        prev_spot = take_win ? win_lead : frame_lead;
        res.x           = OUT_XY_W'(prev_spot.x);
        res.y           = OUT_XY_W'(prev_spot.y);
        res.score       = prev_spot.score;
        res.from_window = take_win;
        spot_q.push_back(res);
        clear_leads();
        col = '0;
        row = '0;
    endtask

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    always @(posedge i_clk) begin
        t_spot_result want;
        if (!i_rst_n) begin
            hue_w     = RST_HUE_WEIGHT;
            sat_w     = RST_SATURATION_WEIGHT;
            val_w     = RST_VALUE_WEIGHT;
            half_w    = RST_HALF_WINDOW;
            col       = '0;
            row       = '0;
            prev_spot = '{'0, '0, '0};
            clear_leads();
            spot_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HUE_WEIGHT:        hue_w  = i_cfg_data[WGT_W-1:0];
                    CFG_SATURATION_WEIGHT: sat_w  = i_cfg_data[WGT_W-1:0];
                    CFG_VALUE_WEIGHT:      val_w  = i_cfg_data[WGT_W-1:0];
                    CFG_HALF_WINDOW:       half_w = i_cfg_data[HALF_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (spot_q.size() == 0) begin
                    $error("spot transfer with nothing pending: x=%0d y=%0d score=%0d",
                           i_spot_x, i_spot_y, i_spot_score);
                    o_mismatch_count++;
                end else begin
                    want = spot_q.pop_front();
                    if (i_spot_x !== want.x) begin
                        $error("spot_x: expected %0d, got %0d", want.x, i_spot_x);
                        o_mismatch_count++;
                    end
                    if (i_spot_y !== want.y) begin
                        $error("spot_y: expected %0d, got %0d", want.y, i_spot_y);
                        o_mismatch_count++;
                    end
                    if (i_spot_score !== want.score) begin
                        $error("spot_score: expected %0d, got %0d", want.score, i_spot_score);
                        o_mismatch_count++;
                    end
                    if (i_from_window !== want.from_window) begin
                        $error("from_window: expected %0d, got %0d",
                               want.from_window, i_from_window);
                        o_mismatch_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                track_pixel(i_hue, i_saturation, i_brightness, i_frame_end);
            end
        end
        o_pending = spot_q.size();
    end

endmodule

// ===== tb/sv/tb_laser_spot_window_tracker.sv =====
`timescale 1ns / 100ps
// Top of the laser spot window tracker testbench: clock, reset, config writes,
// pixel stimulus and result back-pressure, plus the final verdict.
// Depends on lswt_pkg, laser_spot_window_tracker and lswt_spot_checker.
module tb_laser_spot_window_tracker;
    import lswt_pkg::*;

    // Generous ceiling on the whole run; a correct run needs a small part of it
    localparam longint TIMEOUT_NS = 10_000_000;
    localparam int     MIN_PIXELS = 950;
    localparam int     MIN_FRAMES = 20;
    localparam int     IDLE_WAIT  = 8;

    typedef enum int {FRAME_NOISE, FRAME_FLAT, FRAME_SPOT} t_frame_kind;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CHAN_W-1:0]     i_hue;
    logic [CHAN_W-1:0]     i_saturation;
    logic [CHAN_W-1:0]     i_brightness;
    logic                  i_frame_end;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [OUT_XY_W-1:0]   o_spot_x;
    logic [OUT_XY_W-1:0]   o_spot_y;
    logic [SCORE_W-1:0]    o_spot_score;
    logic                  o_from_window;

    int mismatch_count;
    int pending;
    int pixels_sent;
    int frames_sent;
    int burst_left;
    int aim_x;
    int aim_y;

    laser_spot_window_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_hue         (i_hue),
        .i_saturation  (i_saturation),
        .i_brightness  (i_brightness),
        .i_frame_end   (i_frame_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_spot_x      (o_spot_x),
        .o_spot_y      (o_spot_y),
        .o_spot_score  (o_spot_score),
        .o_from_window (o_from_window)
    );

    lswt_spot_checker u_spot_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_hue            (i_hue),
        .i_saturation     (i_saturation),
        .i_brightness     (i_brightness),
        .i_frame_end      (i_frame_end),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_spot_x         (o_spot_x),
        .i_spot_y         (o_spot_y),
        .i_spot_score     (o_spot_score),
        .i_from_window    (o_from_window),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Result back-pressure: stretches of steady ready, coin-flip ready and
    // mostly-stalled ready, each of random length. Drive at the falling edge.
    initial begin
        int mode;
        int span;
        i_out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Write one register; the caller drops the write enable after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
    endtask

    task automatic apply_config(input int unsigned hue_w, input int unsigned sat_w,
                                input int unsigned val_w, input int unsigned half_data);
        write_reg(CFG_HUE_WEIGHT, hue_w);
        write_reg(CFG_SATURATION_WEIGHT, sat_w);
        write_reg(CFG_VALUE_WEIGHT, val_w);
        write_reg(CFG_HALF_WINDOW, half_data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, hold off until every pending spot has come out, then let the
    // pipeline drain its trailing pixels before anything touches the registers.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    // Sender pacing: bursts of back-to-back transfers split by short gaps,
    // with an occasional long burst. Scramble the payload while idle.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_in_valid   <= 1'b0;
            i_hue        <= CHAN_W'($urandom);
            i_saturation <= CHAN_W'($urandom);
            i_brightness <= CHAN_W'($urandom);
            i_frame_end  <= 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    // Present one pixel and hold it until the transfer completes
    task automatic send_pixel(input int unsigned hue, input int unsigned sat,
                              input int unsigned bri, input logic is_end);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_hue        <= CHAN_W'(hue);
        i_saturation <= CHAN_W'(sat);
        i_brightness <= CHAN_W'(bri);
        i_frame_end  <= is_end;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
        pace();
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > FRAME_SIDE - 1) begin
            return FRAME_SIDE - 1;
        end
        return v;
    endfunction

    // One frame of len pixels, frame end on the last one. Spot frames put a
    // bright pixel near the last spot over a dim background, sometimes with a
    // decoy elsewhere, so the window and the fallback both get exercised.
    task automatic send_frame(input int len, input t_frame_kind kind);
        int          sx, sy, spot_idx, decoy_idx, bg;
        int unsigned flat_h, flat_s, flat_b, ph, ps, pb;
        sx = clamp_coord(aim_x + int'($urandom_range(0, 16)) - 8);
        sy = clamp_coord(aim_y + int'($urandom_range(0, 4)) - 2);
        spot_idx = sy * FRAME_SIDE + sx;
        if (spot_idx >= len) begin
            spot_idx = $urandom_range(0, len - 1);
        end
        aim_x     = spot_idx % FRAME_SIDE;
        aim_y     = spot_idx / FRAME_SIDE;
        decoy_idx = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, len - 1)) : -1;
        bg        = $urandom_range(0, 120);
        flat_h    = $urandom_range(0, 255);
        flat_s    = $urandom_range(0, 255);
        flat_b    = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            case (kind)
                FRAME_NOISE: begin
                    ph = $urandom_range(0, 255);
                    ps = $urandom_range(0, 255);
                    pb = $urandom_range(0, 255);
                end
                FRAME_FLAT: begin
                    ph = flat_h;
                    ps = flat_s;
                    pb = flat_b;
                end
                default: begin
                    if (i == spot_idx) begin
                        ph = $urandom_range(120, 255);
                        ps = $urandom_range(120, 255);
                        pb = $urandom_range(120, 255);
                    end else if (i == decoy_idx) begin
                        ph = $urandom_range(60, 255);
                        ps = $urandom_range(60, 255);
                        pb = $urandom_range(60, 255);
                    end else begin
                        ph = $urandom_range(0, bg);
                        ps = $urandom_range(0, bg);
                        pb = $urandom_range(0, bg);
                    end
                end
            endcase
            send_pixel(ph, ps, pb, i == len - 1);
        end
        frames_sent++;
    endtask

    function automatic int unsigned pick_weight();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Half window choices lean on the edges: empty, one pixel, just under and
    // over a full-frame window, the top of the 7-bit range. Bit 7 of the data
    // is random since the register keeps only the low bits.
    function automatic int unsigned pick_half_data();
        int unsigned half;
        case ($urandom_range(0, 7))
            0:       half = 0;
            1:       half = 1;
            2:       half = 63;
            3:       half = 64;
            4:       half = 127;
            default: half = $urandom_range(1, 24);
        endcase
        return ($urandom_range(0, 1) << 7) | half;
    endfunction

    function automatic int frame_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return $urandom_range(1, 12);
        end
        if (r < 95) begin
            return $urandom_range(13, 160);
        end
        return $urandom_range(161, 520);
    endfunction

    function automatic t_frame_kind frame_kind();
        case ($urandom_range(0, 9))
            0, 1:    return FRAME_NOISE;
            2:       return FRAME_FLAT;
            default: return FRAME_SPOT;
        endcase
    endfunction

    initial begin
        int frames;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_hue        = '0;
        i_saturation = '0;
        i_brightness = '0;
        i_frame_end  = 1'b0;
        pixels_sent  = 0;
        frames_sent  = 0;
        burst_left   = 0;
        aim_x        = 0;
        aim_y        = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset weights. A blank single-pixel frame
        // must give all zeros; two equal maxima keep the first one and the
        // window wins; then a window spot too dim against the last spot falls
        // back to the frame best.
        send_pixel(0, 0, 0, 1'b1);
        send_pixel(255, 255, 255, 1'b0);
        send_pixel(255, 255, 255, 1'b0);
        send_pixel(0, 0, 0, 1'b1);
        send_pixel(1, 0, 0, 1'b0);
        send_pixel(0, 0, 5, 1'b1);

        // Largest weights and a window as wide as the frame: top score
        settle();
        apply_config(255, 255, 255, 64);
        send_pixel(0, 255, 0, 1'b0);
        send_pixel(255, 255, 255, 1'b0);
        send_pixel(255, 0, 0, 1'b1);

        // Zero weights score everything zero; half window masks down to zero
        settle();
        apply_config(0, 0, 0, 8'h80);
        send_pixel(255, 255, 255, 1'b0);
        send_pixel(17, 200, 3, 1'b1);

        // Smallest nonzero window
        settle();
        apply_config(0, 0, 255, 1);
        send_pixel(0, 0, 9, 1'b0);
        send_pixel(0, 0, 200, 1'b0);
        send_pixel(0, 0, 100, 1'b1);

        // Random phases: fresh register set, then a few frames each
        while (pixels_sent < MIN_PIXELS || frames_sent < MIN_FRAMES) begin
            settle();
            apply_config(pick_weight(), pick_weight(), pick_weight(), pick_half_data());
            frames = $urandom_range(1, 4);
            repeat (frames) send_frame(frame_length(), frame_kind());
        end

        // Two frames a few rows long: the first leaves the spot near the right
        // edge so the next window clamps at the far column; the second runs
        // past the end of a row so the column wraps before frame end.
        settle();
        apply_config($urandom_range(1, 255), $urandom_range(1, 255),
                     $urandom_range(1, 255), 21);
        aim_x = 120;
        aim_y = 1;
        send_frame(2 * FRAME_SIDE, FRAME_SPOT);
        aim_x = 110;
        aim_y = 1;
        send_frame(2 * FRAME_SIDE + 40, FRAME_SPOT);

        settle();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
